>>> rtl/pbd_pkg.sv
// Shared types and constants for the padded block deframer.
package pbd_pkg;

    // Stream phase of the deframer
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_CONTENT = 2'd1,
        PH_PADDING = 2'd2,
        PH_ERROR   = 2'd3
    } phase_t;

    // Result kind codes
    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_END     = 2'd1,
        KIND_BAD_CMD = 2'd2,
        KIND_SIZE    = 2'd3
    } kind_t;

    // Command index codes
    localparam logic [1:0] CMD_CONTINUE = 2'd0;
    localparam logic [1:0] CMD_END      = 2'd1;
    localparam logic [1:0] CMD_DIRECT   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_MAX_PAYLOAD   = 2'd0;
    localparam logic [1:0] REG_CODE_CONTINUE = 2'd1;
    localparam logic [1:0] REG_CODE_END      = 2'd2;
    localparam logic [1:0] REG_CODE_DIRECT   = 2'd3;

    // Widths
    localparam int unsigned SIZE_W   = 18;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned HCOUNT_W = 3;

    // Header layout and register reset values
    localparam logic [HCOUNT_W-1:0] HDR_LAST_IDX      = 3'd4;
    localparam logic [SIZE_W-1:0]   HDR_SIZE          = 18'd5;
    localparam logic [SIZE_W-1:0]   MAX_PAYLOAD_RST   = 18'd16384;
    localparam logic [BYTE_W-1:0]   CODE_CONTINUE_RST = 8'd0;
    localparam logic [BYTE_W-1:0]   CODE_END_RST      = 8'd1;
    localparam logic [BYTE_W-1:0]   CODE_DIRECT_RST   = 8'd2;

endpackage

>>> rtl/padded_block_deframer_unit.sv
// Padded block deframer: splits a byte stream into length-prefixed padded blocks.
//
// Input channel (in_valid, in_stall, in_byte) takes one stream byte per transfer.
// Each block is a 5-byte header (command byte, big-endian content length,
// big-endian padding length), then content, then padding. Content bytes come
// out on the output channel (out_valid, out_stall, kind, content_byte,
// cmd_index, block_last) tagged with the command index; padding is dropped.
// An empty block or the last padding byte gives an end marker with no data.
// A bad command or an oversized block gives one error result, after which
// every byte is consumed silently until reset.
// A transferred byte waits in the input register; its result (if any) is loaded
// into the result register when it advances. Throughput: one byte per cycle
// unless the receiver stalls, set by the single-pass header compare and counter
// update. Reset puts the configuration registers at their defaults and the stream
// in the header phase. When the receiver stalls, the result register holds; one
// more byte waits in the input register, after which in_stall rises.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once; the user
// must make them only while the block is idle, as the block does not enforce this.
module padded_block_deframer_unit
    import pbd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [SIZE_W-1:0]   cfg_data,
    // input stream
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [BYTE_W-1:0]   in_byte,
    // output stream
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          kind,
    output logic [BYTE_W-1:0]   content_byte,
    output logic [1:0]          cmd_index,
    output logic                block_last
);

    // Configuration registers
    logic [SIZE_W-1:0]   max_payload_reg;
    logic [BYTE_W-1:0]   code_continue_reg;
    logic [BYTE_W-1:0]   code_end_reg;
    logic [BYTE_W-1:0]   code_direct_reg;

    // Input register
    logic                s1_valid_reg;
    logic [BYTE_W-1:0]   s1_byte_reg;
    logic                s1_adv;

    // Stream state
    phase_t              phase_reg, phase_next;
    logic [HCOUNT_W-1:0] hdr_count_reg, hdr_count_next;
    logic [31:0]         hdr_reg, hdr_next;
    logic [1:0]          cmd_held_reg, cmd_held_next;
    logic [LEN_W-1:0]    content_left_reg, content_left_next;
    logic [LEN_W-1:0]    padding_left_reg, padding_left_next;

    // Result of the current byte
    logic                res_valid;
    kind_t               res_kind;
    logic [BYTE_W-1:0]   res_byte;
    logic [1:0]          res_cmd;
    logic                res_last;

    // Result register
    logic                out_valid_reg;
    kind_t               out_kind_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic [1:0]          out_cmd_reg;
    logic                out_last_reg;

    // Header decode
    logic [BYTE_W-1:0]   hdr_cmd;
    logic [LEN_W-1:0]    hdr_clen;
    logic [LEN_W-1:0]    hdr_plen;
    logic [SIZE_W-1:0]   size_sum;
    logic                size_bad;
    logic                cmd_ok;
    logic [1:0]          cmd_match;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg   <= MAX_PAYLOAD_RST;
            code_continue_reg <= CODE_CONTINUE_RST;
            code_end_reg      <= CODE_END_RST;
            code_direct_reg   <= CODE_DIRECT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAX_PAYLOAD:   max_payload_reg   <= cfg_data;
                REG_CODE_CONTINUE: code_continue_reg <= cfg_data[BYTE_W-1:0];
                REG_CODE_END:      code_end_reg      <= cfg_data[BYTE_W-1:0];
                REG_CODE_DIRECT:   code_direct_reg   <= cfg_data[BYTE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Advance the input register when the result slot is free or draining
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;

    // Hold the accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= in_byte;
        end
    end

    // Decode the header as its last byte arrives
    assign hdr_cmd  = hdr_reg[31:24];
    assign hdr_clen = hdr_reg[23:8];
    assign hdr_plen = {hdr_reg[7:0], s1_byte_reg};
    assign size_sum = {2'b00, hdr_clen} + {2'b00, hdr_plen} + HDR_SIZE;
    assign size_bad = size_sum > max_payload_reg;

    // First matching code gives the command index
    always_comb
    begin
        cmd_ok    = 1'b1;
        cmd_match = CMD_CONTINUE;
        if (hdr_cmd == code_continue_reg)
        begin
            cmd_match = CMD_CONTINUE;
        end
        else if (hdr_cmd == code_end_reg)
        begin
            cmd_match = CMD_END;
        end
        else if (hdr_cmd == code_direct_reg)
        begin
            cmd_match = CMD_DIRECT;
        end
        else
        begin
            cmd_ok = 1'b0;
        end
    end

    // Next stream state and result
    always_comb
    begin
        phase_next        = phase_reg;
        hdr_count_next    = hdr_count_reg;
        hdr_next          = hdr_reg;
        cmd_held_next     = cmd_held_reg;
        content_left_next = content_left_reg;
        padding_left_next = padding_left_reg;
        res_valid         = 1'b0;
        res_kind          = KIND_DATA;
        res_byte          = '0;
        res_cmd           = cmd_held_reg;
        res_last          = 1'b0;

        if (s1_adv)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    hdr_next = {hdr_reg[23:0], s1_byte_reg};
                    if (hdr_count_reg != HDR_LAST_IDX)
                    begin
                        hdr_count_next = hdr_count_reg + 1'b1;
                    end
                    else
                    begin
                        hdr_count_next = '0;
                        if (!cmd_ok)
                        begin
                            phase_next = PH_ERROR;
                            res_valid  = 1'b1;
                            res_kind   = KIND_BAD_CMD;
                            res_cmd    = CMD_CONTINUE;
                        end
                        else
                        begin
                            cmd_held_next = cmd_match;
                            res_cmd       = cmd_match;
                            if (size_bad)
                            begin
                                phase_next = PH_ERROR;
                                res_valid  = 1'b1;
                                res_kind   = KIND_SIZE;
                            end
                            else
                            begin
                                content_left_next = hdr_clen;
                                padding_left_next = hdr_plen;
                                if (hdr_clen != '0)
                                begin
                                    phase_next = PH_CONTENT;
                                end
                                else if (hdr_plen != '0)
                                begin
                                    phase_next = PH_PADDING;
                                end
                                else
                                begin
                                    res_valid = 1'b1;
                                    res_kind  = KIND_END;
                                    res_last  = 1'b1;
                                end
                            end
                        end
                    end
                end
                PH_CONTENT:
                begin
                    content_left_next = content_left_reg - 1'b1;
                    res_valid         = 1'b1;
                    res_kind          = KIND_DATA;
                    res_byte          = s1_byte_reg;
                    if (content_left_reg == LEN_W'(1))
                    begin
                        if (padding_left_reg == '0)
                        begin
                            phase_next = PH_HEADER;
                            res_last   = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_PADDING;
                        end
                    end
                end
                PH_PADDING:
                begin
                    padding_left_next = padding_left_reg - 1'b1;
                    if (padding_left_reg == LEN_W'(1))
                    begin
                        phase_next = PH_HEADER;
                        res_valid  = 1'b1;
                        res_kind   = KIND_END;
                        res_last   = 1'b1;
                    end
                end
                default:
                begin
                    // error phase: drop the byte
                end
            endcase
        end
    end

    // Stream state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HEADER;
            hdr_count_reg    <= '0;
            hdr_reg          <= '0;
            cmd_held_reg     <= CMD_CONTINUE;
            content_left_reg <= '0;
            padding_left_reg <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            hdr_count_reg    <= hdr_count_next;
            hdr_reg          <= hdr_next;
            cmd_held_reg     <= cmd_held_next;
            content_left_reg <= content_left_next;
            padding_left_reg <= padding_left_next;
        end
    end

    // Result register: load on advance, drop after the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= res_valid;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && res_valid)
        begin
            out_kind_reg <= res_kind;
            out_byte_reg <= res_byte;
            out_cmd_reg  <= res_cmd;
            out_last_reg <= res_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_kind_reg;
    assign content_byte = out_byte_reg;
    assign cmd_index    = out_cmd_reg;
    assign block_last   = out_last_reg;

    // Error phase is sticky
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ERROR |=> phase_reg == PH_ERROR)
        else $error("error phase left before reset");

    // Content phase always has bytes left
    a_content_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_CONTENT |-> content_left_reg != '0)
        else $error("content phase with zero content left");

    // Non-data results carry a zero byte
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_DATA |-> content_byte == '0)
        else $error("non-data result with nonzero byte");

    // Errors never close a block
    a_error_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_BAD_CMD || kind == KIND_SIZE) |-> !block_last)
        else $error("error result marked last");

    // Input stalls only while the result slot is full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && s1_valid_reg)
        else $error("input stalled with a free slot");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the padded block deframer unit.
`timescale 1ns / 100ps

module tb_top;
    import pbd_pkg::*;

    // Expected result of one byte
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [1:0] cmd;
        logic       last;
    } frag_t;

    // Where the expectation of a byte comes from
    typedef enum logic [1:0] {
        CHK_MODEL  = 2'd0,  // predictor
        CHK_GIVEN  = 2'd1,  // typed-in result
        CHK_SILENT = 2'd2   // typed-in: no result
    } chk_t;

    typedef struct packed {
        logic [7:0] b;
        chk_t       mode;
        frag_t      exp;
    } row_t;

    localparam int          HDR_LEN    = 5;
    localparam int          SEG_ITEMS  = 150;
    localparam int          RAND_STOP  = 1850;
    localparam int          LONG_HOLD  = 300;
    localparam int          SETTLE     = 4;
    localparam int          LIMIT      = 500000;
    localparam frag_t       NO_FRAG    = '0;
    localparam logic [17:0] TAIL_MAX   = 18'd1000;
    localparam logic [7:0]  TAIL_CONT  = 8'd3;
    localparam logic [7:0]  TAIL_END   = 8'd4;
    localparam logic [7:0]  TAIL_DIR   = 8'd5;

    // Directed stream under the reset configuration
    row_t dir_table [26] = '{
        // empty block, continue
        {8'h00, CHK_MODEL,  NO_FRAG},
        {8'h00, CHK_MODEL,  NO_FRAG},
        {8'h00, CHK_MODEL,  NO_FRAG},
        {8'h00, CHK_MODEL,  NO_FRAG},
        {8'h00, CHK_GIVEN,  KIND_END,  8'h00, CMD_CONTINUE, 1'b1},
        // unpadded block, end, two content bytes
        {8'h01, CHK_MODEL,  NO_FRAG},
        {8'h00, CHK_MODEL,  NO_FRAG},
        {8'h02, CHK_MODEL,  NO_FRAG},
        {8'h00, CHK_MODEL,  NO_FRAG},
        {8'h00, CHK_SILENT, NO_FRAG},
        {8'hFF, CHK_GIVEN,  KIND_DATA, 8'hFF, CMD_END, 1'b0},
        {8'h00, CHK_GIVEN,  KIND_DATA, 8'h00, CMD_END, 1'b1},
        // padded block, direct, one content byte and two padding bytes
        {8'h02, CHK_MODEL,  NO_FRAG},
        {8'h00, CHK_MODEL,  NO_FRAG},
        {8'h01, CHK_MODEL,  NO_FRAG},
        {8'h00, CHK_MODEL,  NO_FRAG},
        {8'h02, CHK_SILENT, NO_FRAG},
        {8'hAA, CHK_GIVEN,  KIND_DATA, 8'hAA, CMD_DIRECT, 1'b0},
        {8'h55, CHK_SILENT, NO_FRAG},
        {8'h11, CHK_GIVEN,  KIND_END,  8'h00, CMD_DIRECT, 1'b1},
        // padding only, continue
        {8'h00, CHK_MODEL,  NO_FRAG},
        {8'h00, CHK_MODEL,  NO_FRAG},
        {8'h00, CHK_MODEL,  NO_FRAG},
        {8'h00, CHK_MODEL,  NO_FRAG},
        {8'h01, CHK_SILENT, NO_FRAG},
        {8'h7E, CHK_GIVEN,  KIND_END,  8'h00, CMD_CONTINUE, 1'b1}
    };

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [SIZE_W-1:0]   cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic [BYTE_W-1:0]   in_byte;
    logic                out_valid;
    logic                out_stall;
    logic [1:0]          kind;
    logic [BYTE_W-1:0]   content_byte;
    logic [1:0]          cmd_index;
    logic                block_last;

    // Check source that travels with the byte on the input
    chk_t  in_chk;
    frag_t in_given;

    // Predictor configuration copy
    logic [SIZE_W-1:0] cfg_max;
    logic [7:0]        code_cont;
    logic [7:0]        code_end;
    logic [7:0]        code_dir;

    // Predictor state
    phase_t      ph;
    logic [2:0]  hcount;
    logic [39:0] hdr;
    logic [1:0]  cmd_cur;
    logic [15:0] clen_left;
    logic [15:0] plen_left;

    frag_t pending_frags[$];
    int    mismatches = 0;
    int    items_sent = 0;
    int    cycles = 0;

    // Receiver control
    bit tx_no_idle = 1'b0;
    bit rx_no_idle = 1'b0;
    bit long_hold_req = 1'b0;
    bit rx_took = 1'b0;
    int rx_wait = 0;

    padded_block_deframer_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .content_byte (content_byte),
        .cmd_index    (cmd_index),
        .block_last   (block_last)
    );

    always #10 clk = ~clk;

    function automatic frag_t make_frag(kind_t k, logic [7:0] d, logic [1:0] c, logic l);
        frag_t f;
        f.kind = k;
        f.data = d;
        f.cmd  = c;
        f.last = l;
        return f;
    endfunction

    function automatic int draw_gap(bit no_idle);
        return no_idle ? 0 : int'($urandom_range(0, 19));
    endfunction

    // Mostly short lengths, now and then a few hundred bytes of content
    function automatic int unsigned draw_len(bit pad);
        int unsigned r;
        r = $urandom_range(0, 19);
        if (pad)
        begin
            if (r < 8)
                return 0;
            return (r < 18) ? $urandom_range(1, 6) : $urandom_range(7, 30);
        end
        if (r < 14)
            return $urandom_range(0, 6);
        return (r < 19) ? $urandom_range(7, 40) : $urandom_range(200, 300);
    endfunction

    // Advance the predictor by one stream byte; return 1 when it yields a result
    function automatic bit deframe_byte(input logic [7:0] b, output frag_t r);
        logic [7:0]  cmd_byte;
        logic [15:0] clen;
        logic [15:0] plen;
        int unsigned total;
        logic        last;
        r = NO_FRAG;
        case (ph)
            PH_HEADER:
            begin
                hdr    = {hdr[31:0], b};
                hcount = hcount + 3'd1;
                if (hcount != HDR_LEN)
                    return 1'b0;
                hcount   = '0;
                cmd_byte = hdr[39:32];
                clen     = hdr[31:16];
                plen     = hdr[15:0];
                // first matching code wins
                if (cmd_byte == code_cont)
                    cmd_cur = CMD_CONTINUE;
                else if (cmd_byte == code_end)
                    cmd_cur = CMD_END;
                else if (cmd_byte == code_dir)
                    cmd_cur = CMD_DIRECT;
                else
                begin
                    ph = PH_ERROR;
                    r  = make_frag(KIND_BAD_CMD, 8'd0, CMD_CONTINUE, 1'b0);
                    return 1'b1;
                end
                total = clen + plen + HDR_LEN;
                if (total > cfg_max)
                begin
                    ph = PH_ERROR;
                    r  = make_frag(KIND_SIZE, 8'd0, cmd_cur, 1'b0);
                    return 1'b1;
                end
                clen_left = clen;
                plen_left = plen;
                if (clen != 0)
                    ph = PH_CONTENT;
                else if (plen != 0)
                    ph = PH_PADDING;
                else
                begin
                    r = make_frag(KIND_END, 8'd0, cmd_cur, 1'b1);
                    return 1'b1;
                end
            end
            PH_CONTENT:
            begin
                last      = 1'b0;
                clen_left = clen_left - 16'd1;
                if (clen_left == 0)
                begin
                    if (plen_left == 0)
                    begin
                        ph   = PH_HEADER;
                        last = 1'b1;
                    end
                    else
                        ph = PH_PADDING;
                end
                r = make_frag(KIND_DATA, b, cmd_cur, last);
                return 1'b1;
            end
            PH_PADDING:
            begin
                plen_left = plen_left - 16'd1;
                if (plen_left == 0)
                begin
                    ph = PH_HEADER;
                    r  = make_frag(KIND_END, 8'd0, cmd_cur, 1'b1);
                    return 1'b1;
                end
            end
            default:
                ;
        endcase
        return 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Offer one byte after a random gap and hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input chk_t mode, input frag_t given);
        int gap;
        gap = draw_gap(tx_no_idle);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_chk   <= mode;
        in_given <= given;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Send one well-formed block that fits the current size limit
    task automatic send_block();
        int unsigned room;
        int unsigned clen;
        int unsigned plen;
        logic [7:0]  cmd_byte;
        case ($urandom_range(0, 2))
            0:       cmd_byte = code_cont;
            1:       cmd_byte = code_end;
            default: cmd_byte = code_dir;
        endcase
        room = cfg_max - HDR_LEN;
        clen = draw_len(1'b0);
        plen = draw_len(1'b1);
        if (clen > room)
            clen = room;
        if (clen + plen > room)
            plen = room - clen;
        // now and then fill the limit exactly
        if (room <= 600 && $urandom_range(0, 7) == 0)
        begin
            clen = $urandom_range(0, room);
            plen = room - clen;
        end
        send_byte(cmd_byte, CHK_MODEL, NO_FRAG);
        send_byte(clen[15:8], CHK_MODEL, NO_FRAG);
        send_byte(clen[7:0], CHK_MODEL, NO_FRAG);
        send_byte(plen[15:8], CHK_MODEL, NO_FRAG);
        send_byte(plen[7:0], CHK_MODEL, NO_FRAG);
        repeat (clen) send_byte(8'($urandom), CHK_MODEL, NO_FRAG);
        repeat (plen) send_byte(8'($urandom), CHK_MODEL, NO_FRAG);
    endtask

    // Stop the sender until every result is in, then set the idling for the next phase
    task automatic pause_until_drained(input bit tx_fast, input bit rx_fast, input bit hold);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_frags.size() != 0)
            @(posedge clk);
        // a header byte may still sit in the input register
        repeat (SETTLE) @(posedge clk);
        tx_no_idle = tx_fast;
        rx_no_idle = rx_fast;
        if (hold)
            long_hold_req = 1'b1;
        @(negedge clk);
    endtask

    task automatic apply_config(input logic [17:0] mp, input logic [7:0] cc,
                                input logic [7:0] ce, input logic [7:0] cd);
        cfg_max   = mp;
        code_cont = cc;
        code_end  = ce;
        code_dir  = cd;
        cfg_we    <= 1'b1;
        cfg_index <= REG_MAX_PAYLOAD;
        cfg_data  <= mp;
        @(negedge clk);
        cfg_index <= REG_CODE_CONTINUE;
        cfg_data  <= SIZE_W'(cc);
        @(negedge clk);
        cfg_index <= REG_CODE_END;
        cfg_data  <= SIZE_W'(ce);
        @(negedge clk);
        cfg_index <= REG_CODE_DIRECT;
        cfg_data  <= SIZE_W'(cd);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Check each result transfer, then predict each byte transfer
    always @(posedge clk)
    begin : watch
        frag_t want;
        frag_t got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                rx_took = 1'b1;
                if (pending_frags.size() == 0)
                    report_mismatch("result with nothing pending, kind", kind, -1);
                else
                begin
                    want = pending_frags.pop_front();
                    if (kind != want.kind)
                        report_mismatch("kind", kind, want.kind);
                    if (content_byte != want.data)
                        report_mismatch("content_byte", content_byte, want.data);
                    if (cmd_index != want.cmd)
                        report_mismatch("cmd_index", cmd_index, want.cmd);
                    if (block_last != want.last)
                        report_mismatch("block_last", block_last, want.last);
                end
            end
            if (in_valid && !in_stall)
            begin
                if (deframe_byte(in_byte, got) && in_chk == CHK_MODEL)
                    pending_frags = {pending_frags, got};
                if (in_chk == CHK_GIVEN)
                    pending_frags = {pending_frags, in_given};
            end
        end
    end

    // Draw a stall count per result; a long hold request overrides it
    always @(negedge clk)
    begin
        if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            rx_took       = 1'b0;
            rx_wait       = LONG_HOLD;
        end
        else if (rx_took)
        begin
            rx_took = 1'b0;
            rx_wait = draw_gap(rx_no_idle);
        end
        else if (rx_wait > 0)
            rx_wait = rx_wait - 1;
        out_stall <= (rx_wait > 0);
    end

    // Drop the run if it hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned seg;
        int          seg_start;
        bit          tx_fast;
        bit          rx_fast;
        logic [7:0]  hb [5];
        frag_t       err_frag;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_MAX_PAYLOAD;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_byte   = '0;
        in_chk    = CHK_MODEL;
        in_given  = NO_FRAG;
        out_stall = 1'b0;
        cfg_max   = MAX_PAYLOAD_RST;
        code_cont = CODE_CONTINUE_RST;
        code_end  = CODE_END_RST;
        code_dir  = CODE_DIRECT_RST;
        ph        = PH_HEADER;
        hcount    = '0;
        hdr       = '0;
        cmd_cur   = CMD_CONTINUE;
        clen_left = '0;
        plen_left = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed stream on the reset configuration
        foreach (dir_table[i])
            send_byte(dir_table[i].b, dir_table[i].mode, dir_table[i].exp);

        // random blocks, one configuration per phase
        seg = 0;
        while (items_sent < RAND_STOP)
        begin
            tx_fast = (seg == 5) || ($urandom_range(0, 3) == 0);
            rx_fast = (seg != 5) && ($urandom_range(0, 3) == 0);
            pause_until_drained(tx_fast, rx_fast, seg == 5);
            case (seg)
                0:
                    ;
                1:
                    // only empty blocks fit
                    apply_config(HDR_SIZE, 8'hFF, 8'h00, 8'h80);
                2:
                    // largest limit, continue and end share a code
                    apply_config(18'd131075, 8'h07, 8'h07, 8'h09);
                3:
                    apply_config(18'd40, 8'h44, 8'h33, 8'h33);
                4:
                    apply_config(18'($urandom_range(5, 700)), 8'hA5, 8'hA5, 8'hA5);
                default:
                    apply_config(($urandom_range(0, 3) == 0) ? 18'($urandom_range(5, 131075))
                                                             : 18'($urandom_range(5, 700)),
                                 8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            seg_start = items_sent;
            while (items_sent - seg_start < SEG_ITEMS)
                send_block();
            seg++;
        end

        // close with one error, then bytes that must be swallowed
        pause_until_drained(1'b0, 1'b0, 1'b0);
        apply_config(TAIL_MAX, TAIL_CONT, TAIL_END, TAIL_DIR);
        if ($urandom_range(0, 1) == 0)
        begin
            // bad command, lengths often oversized too: the command is checked first
            hb[0] = 8'($urandom_range(TAIL_DIR + 1, 255));
            for (int i = 1; i < 5; i++)
                hb[i] = ($urandom_range(0, 1) == 0) ? 8'hFF : 8'($urandom);
            err_frag = make_frag(KIND_BAD_CMD, 8'd0, CMD_CONTINUE, 1'b0);
        end
        else
        begin
            // size error: either far over the limit or one byte over it
            hb[0] = TAIL_END;
            if ($urandom_range(0, 1) == 0)
                {hb[1], hb[2], hb[3], hb[4]} = 32'hFFFF_FFFF;
            else
                {hb[1], hb[2], hb[3], hb[4]} = {16'd500, 16'(TAIL_MAX - 18'd504)};
            err_frag = make_frag(KIND_SIZE, 8'd0, CMD_END, 1'b0);
        end
        for (int i = 0; i < 4; i++)
            send_byte(hb[i], CHK_SILENT, NO_FRAG);
        send_byte(hb[4], CHK_GIVEN, err_frag);
        repeat (20) send_byte(8'($urandom), CHK_SILENT, NO_FRAG);

        // wait out the last results
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_frags.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
